>>> design/mbb_pkg.sv
package mbb_pkg;

  localparam int SCREEN_WIDTH_DEF  = 240;
  localparam int SCREEN_HEIGHT_DEF = 320;

  localparam int COORD_W = 10;

  localparam logic [7:0] CMD_COLUMN_SET   = 8'h2A;
  localparam logic [7:0] CMD_ROW_SET      = 8'h2B;
  localparam logic [7:0] CMD_MEMORY_WRITE = 8'h2C;

  localparam logic OP_START = 1'b0;
  localparam logic OP_BYTE  = 1'b1;

  localparam logic [2:0] REG_WIN_LEFT   = 3'd0;
  localparam logic [2:0] REG_WIN_TOP    = 3'd1;
  localparam logic [2:0] REG_BMP_WIDTH  = 3'd2;
  localparam logic [2:0] REG_BMP_HEIGHT = 3'd3;
  localparam logic [2:0] REG_FG_COLOR   = 3'd4;
  localparam logic [2:0] REG_BG_COLOR   = 3'd5;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic               is_hdr;
    logic [COORD_W-1:0] col_lo;
    logic [COORD_W-1:0] col_hi;
    logic [COORD_W-1:0] row_lo;
    logic [COORD_W-1:0] row_hi;
    logic [7:0]         pix_byte;
    logic [3:0]         pix_cnt;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

>>> design/mbb_fifo.sv
module mbb_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  mbb_pkg::job_t push_data,
  input  logic          pop,
  output mbb_pkg::job_t pop_data,
  output mbb_pkg::q_stat_t stat
);

  mbb_pkg::job_t mem_r [mbb_pkg::QDEPTH];
  logic [mbb_pkg::QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [mbb_pkg::QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [mbb_pkg::QCNT_W-1:0] count_r, count_nxt;

  localparam logic [mbb_pkg::QPTR_W-1:0] PTR_LAST = mbb_pkg::QPTR_W'(mbb_pkg::QDEPTH - 1);
  localparam logic [mbb_pkg::QCNT_W-1:0] CNT_FULL = mbb_pkg::QCNT_W'(mbb_pkg::QDEPTH);

  assign stat.full  = (count_r == CNT_FULL);
  assign stat.empty = (count_r == '0);
  assign pop_data   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

>>> design/mbb_front.sv
module mbb_front #(
  parameter int SCREEN_WIDTH  = mbb_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = mbb_pkg::SCREEN_HEIGHT_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_operation,
  input  logic [7:0]                  in_bitmap_byte,
  input  logic [15:0]                 win_left,
  input  logic [15:0]                 win_top,
  input  logic [mbb_pkg::COORD_W-1:0] bmp_width,
  input  logic [mbb_pkg::COORD_W-1:0] bmp_height,
  input  mbb_pkg::q_stat_t            q_stat,
  output logic                        push,
  output mbb_pkg::job_t               push_data
);

  localparam int CW = mbb_pkg::COORD_W;
  localparam logic [15:0]   SW16 = 16'(SCREEN_WIDTH);
  localparam logic [15:0]   SH16 = 16'(SCREEN_HEIGHT);
  localparam logic [CW-1:0] SW   = CW'(SCREEN_WIDTH);
  localparam logic [CW-1:0] SH   = CW'(SCREEN_HEIGHT);
  localparam logic [CW-1:0] ROW_MAX = {CW{1'b1}};

  logic [CW-1:0] clip_width_r, clip_width_nxt;
  logic [CW-1:0] clip_height_r, clip_height_nxt;
  logic [CW-1:0] row_count_r, row_count_nxt;
  logic [6:0]    byte_in_row_r, byte_in_row_nxt;
  logic          blit_visible_r, blit_visible_nxt;

  logic          accept;
  logic          start_ok;
  logic [CW-1:0] left10, top10, avail_w, avail_h, cw, ch;
  logic [CW:0]   col_base, col_rem;
  logic [3:0]    npix;
  logic [7:0]    stride, byte_inc;

  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;

  assign left10  = win_left[CW-1:0];
  assign top10   = win_top[CW-1:0];
  assign avail_w = SW - left10;
  assign avail_h = SH - top10;
  assign cw      = (bmp_width > avail_w) ? avail_w : bmp_width;
  assign ch      = (bmp_height > avail_h) ? avail_h : bmp_height;
  assign start_ok = (win_left < SW16) && (win_top < SH16) &&
                    (bmp_width != '0) && (bmp_height != '0);

  assign col_base = {1'b0, byte_in_row_r, 3'b000};
  assign col_rem  = {1'b0, clip_width_r} - col_base;
  always_comb begin
    if ({1'b0, clip_width_r} <= col_base) begin
      npix = '0;
    end else if (col_rem >= (CW+1)'(8)) begin
      npix = 4'd8;
    end else begin
      npix = col_rem[3:0];
    end
  end

  assign stride   = 8'(({1'b0, bmp_width} + (CW+1)'(7)) >> 3);
  assign byte_inc = {1'b0, byte_in_row_r} + 8'd1;

  always_comb begin
    clip_width_nxt   = clip_width_r;
    clip_height_nxt  = clip_height_r;
    row_count_nxt    = row_count_r;
    byte_in_row_nxt  = byte_in_row_r;
    blit_visible_nxt = blit_visible_r;
    push             = 1'b0;
    push_data        = '0;
    if (accept) begin
      if (in_operation == mbb_pkg::OP_START) begin
        row_count_nxt    = '0;
        byte_in_row_nxt  = '0;
        blit_visible_nxt = start_ok;
        clip_width_nxt   = start_ok ? cw : '0;
        clip_height_nxt  = start_ok ? ch : '0;
        push             = start_ok;
        push_data.is_hdr = 1'b1;
        push_data.col_lo = left10;
        push_data.col_hi = left10 + cw - 1'b1;
        push_data.row_lo = top10;
        push_data.row_hi = top10 + ch - 1'b1;
      end else if (blit_visible_r) begin
        push = (row_count_r < clip_height_r) && (npix != '0);
        push_data.is_hdr   = 1'b0;
        push_data.pix_byte = in_bitmap_byte;
        push_data.pix_cnt  = npix;
        if (byte_inc >= stride) begin
          byte_in_row_nxt = '0;
          if (row_count_r != ROW_MAX) begin
            row_count_nxt = row_count_r + 1'b1;
          end
        end else begin
          byte_in_row_nxt = byte_inc[6:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clip_width_r   <= '0;
      clip_height_r  <= '0;
      row_count_r    <= '0;
      byte_in_row_r  <= '0;
      blit_visible_r <= 1'b0;
    end else begin
      clip_width_r   <= clip_width_nxt;
      clip_height_r  <= clip_height_nxt;
      row_count_r    <= row_count_nxt;
      byte_in_row_r  <= byte_in_row_nxt;
      blit_visible_r <= blit_visible_nxt;
    end
  end

endmodule

>>> design/mbb_back.sv
module mbb_back (
  input  logic             clk,
  input  logic             rst_n,
  input  mbb_pkg::q_stat_t q_stat,
  input  mbb_pkg::job_t    pop_data,
  output logic             pop,
  input  logic [15:0]      fg_color,
  input  logic [15:0]      bg_color,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             out_is_data,
  output logic [15:0]      out_bus_word,
  output logic             out_last_of_run
);

  localparam logic [3:0] ST_COL_CMD = 4'd0;
  localparam logic [3:0] ST_COL_SH  = 4'd1;
  localparam logic [3:0] ST_COL_SL  = 4'd2;
  localparam logic [3:0] ST_COL_EH  = 4'd3;
  localparam logic [3:0] ST_COL_EL  = 4'd4;
  localparam logic [3:0] ST_ROW_CMD = 4'd5;
  localparam logic [3:0] ST_ROW_SH  = 4'd6;
  localparam logic [3:0] ST_ROW_SL  = 4'd7;
  localparam logic [3:0] ST_ROW_EH  = 4'd8;
  localparam logic [3:0] ST_ROW_EL  = 4'd9;
  localparam logic [3:0] ST_MEM_CMD = 4'd10;

  mbb_pkg::job_t cur_r;
  logic          cur_valid_r, cur_valid_nxt;
  logic [3:0]    step_r, step_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          out_is_data_r, out_last_r;
  logic [15:0]   out_word_r;

  logic          advance, last_step, w_is_data;
  logic [15:0]   hdr_word, word;
  logic [15:0]   col_lo16, col_hi16, row_lo16, row_hi16;

  assign col_lo16 = 16'(cur_r.col_lo);
  assign col_hi16 = 16'(cur_r.col_hi);
  assign row_lo16 = 16'(cur_r.row_lo);
  assign row_hi16 = 16'(cur_r.row_hi);

  assign advance   = cur_valid_r && (!out_valid_r || out_ready);
  assign last_step = cur_r.is_hdr ? (step_r == ST_MEM_CMD)
                                  : (step_r == cur_r.pix_cnt - 1'b1);
  assign pop       = !q_stat.empty && (!cur_valid_r || (advance && last_step));

  always_comb begin
    unique case (step_r)
      ST_COL_CMD: hdr_word = 16'(mbb_pkg::CMD_COLUMN_SET);
      ST_COL_SH:  hdr_word = {8'h00, col_lo16[15:8]};
      ST_COL_SL:  hdr_word = {8'h00, col_lo16[7:0]};
      ST_COL_EH:  hdr_word = {8'h00, col_hi16[15:8]};
      ST_COL_EL:  hdr_word = {8'h00, col_hi16[7:0]};
      ST_ROW_CMD: hdr_word = 16'(mbb_pkg::CMD_ROW_SET);
      ST_ROW_SH:  hdr_word = {8'h00, row_lo16[15:8]};
      ST_ROW_SL:  hdr_word = {8'h00, row_lo16[7:0]};
      ST_ROW_EH:  hdr_word = {8'h00, row_hi16[15:8]};
      ST_ROW_EL:  hdr_word = {8'h00, row_hi16[7:0]};
      ST_MEM_CMD: hdr_word = 16'(mbb_pkg::CMD_MEMORY_WRITE);
      default:    hdr_word = '0;
    endcase
  end

  assign w_is_data = !cur_r.is_hdr ||
                     !((step_r == ST_COL_CMD) || (step_r == ST_ROW_CMD) ||
                       (step_r == ST_MEM_CMD));
  assign word = cur_r.is_hdr ? hdr_word
                             : (cur_r.pix_byte[step_r[2:0]] ? fg_color : bg_color);

  always_comb begin
    cur_valid_nxt = cur_valid_r;
    step_nxt      = step_r;
    if (pop) begin
      cur_valid_nxt = 1'b1;
      step_nxt      = '0;
    end else if (advance) begin
      if (last_step) begin
        cur_valid_nxt = 1'b0;
      end
      step_nxt = step_r + 1'b1;
    end
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_r <= pop_data;
    end
    if (advance) begin
      out_is_data_r <= w_is_data;
      out_word_r    <= word;
      out_last_r    <= last_step;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_is_data     = out_is_data_r;
  assign out_bus_word    = out_word_r;
  assign out_last_of_run = out_last_r;

endmodule

>>> design/mono_bitmap_blit_stream.sv
// Expands a 1-bit-per-pixel bitmap into a display-controller word stream.
// A start word (operation 0) clips the window set in the registers to the
// screen and yields 11 words: column-set command, four column bytes,
// row-set command, four row bytes, memory-write command. Each following
// bitmap byte (operation 1) yields one color word per visible column,
// bit 0 first, up to 8. Off-screen or empty blits and clipped bytes yield
// nothing. The front end takes one input word per cycle while its
// 4-entry job queue has room; the back end drives one output word per
// cycle while the output is ready. The output port's one-word-per-cycle
// rate sets the sustained throughput.
// Registers at byte addresses 0x00..0x14: win_left, win_top, bmp_width,
// bmp_height, fg_color, bg_color; write them only while the block is idle.
module mono_bitmap_blit_stream #(
  parameter int SCREEN_WIDTH  = mbb_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = mbb_pkg::SCREEN_HEIGHT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_operation,
  input  logic [7:0]  in_bitmap_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_is_data,
  output logic [15:0] out_bus_word,
  output logic        out_last_of_run,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int CW = mbb_pkg::COORD_W;

  logic [15:0]   win_left_r, win_top_r, fg_color_r, bg_color_r;
  logic [CW-1:0] bmp_width_r, bmp_height_r;
  logic [2:0]    reg_idx;
  logic          wr_en;

  mbb_pkg::job_t    push_data, pop_data;
  mbb_pkg::q_stat_t q_stat;
  logic             push, pop;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_left_r   <= '0;
      win_top_r    <= '0;
      bmp_width_r  <= '0;
      bmp_height_r <= '0;
      fg_color_r   <= 16'hFFFF;
      bg_color_r   <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        mbb_pkg::REG_WIN_LEFT:   win_left_r   <= pwdata[15:0];
        mbb_pkg::REG_WIN_TOP:    win_top_r    <= pwdata[15:0];
        mbb_pkg::REG_BMP_WIDTH:  bmp_width_r  <= pwdata[CW-1:0];
        mbb_pkg::REG_BMP_HEIGHT: bmp_height_r <= pwdata[CW-1:0];
        mbb_pkg::REG_FG_COLOR:   fg_color_r   <= pwdata[15:0];
        mbb_pkg::REG_BG_COLOR:   bg_color_r   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      mbb_pkg::REG_WIN_LEFT:   prdata = 32'(win_left_r);
      mbb_pkg::REG_WIN_TOP:    prdata = 32'(win_top_r);
      mbb_pkg::REG_BMP_WIDTH:  prdata = 32'(bmp_width_r);
      mbb_pkg::REG_BMP_HEIGHT: prdata = 32'(bmp_height_r);
      mbb_pkg::REG_FG_COLOR:   prdata = 32'(fg_color_r);
      mbb_pkg::REG_BG_COLOR:   prdata = 32'(bg_color_r);
      default:                 prdata = '0;
    endcase
  end

  mbb_front #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_operation   (in_operation),
    .in_bitmap_byte (in_bitmap_byte),
    .win_left       (win_left_r),
    .win_top        (win_top_r),
    .bmp_width      (bmp_width_r),
    .bmp_height     (bmp_height_r),
    .q_stat         (q_stat),
    .push           (push),
    .push_data      (push_data)
  );

  mbb_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .stat      (q_stat)
  );

  mbb_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_stat          (q_stat),
    .pop_data        (pop_data),
    .pop             (pop),
    .fg_color        (fg_color_r),
    .bg_color        (bg_color_r),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_is_data     (out_is_data),
    .out_bus_word    (out_bus_word),
    .out_last_of_run (out_last_of_run)
  );

endmodule

>>> tb/sv/mono_bitmap_blit_stream_tb.sv
`timescale 1ns / 1ps

module mono_bitmap_blit_stream_tb;
  import mbb_pkg::*;

  localparam int SCREEN_W      = SCREEN_WIDTH_DEF;
  localparam int SCREEN_H      = SCREEN_HEIGHT_DEF;
  localparam int ROW_MAX       = 1023;
  localparam int SETTLE_CYCLES = 64;
  localparam int HOLD_CYCLES   = 300;
  localparam int STALL_LIMIT   = 3000;
  localparam int RANDOM_WORDS  = 140;

  typedef struct packed {
    logic       op;
    logic [7:0] pixels;
  } in_word_t;

  typedef struct packed {
    logic        is_data;
    logic [15:0] value;
    logic        last_flag;
  } out_word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_operation = 1'b0;
  logic [7:0]  in_bitmap_byte = 8'h00;
  logic        out_ready = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = 5'd0;
  logic [31:0] pwdata = 32'd0;
  logic        in_ready;
  logic        out_valid;
  logic        out_is_data;
  logic [15:0] out_bus_word;
  logic        out_last_of_run;
  logic [31:0] prdata;
  logic        pready;

  // register copies and blit state of the predictor
  logic [15:0] cfg_left = 16'd0;
  logic [15:0] cfg_top = 16'd0;
  logic [9:0]  cfg_width = 10'd0;
  logic [9:0]  cfg_height = 10'd0;
  logic [15:0] cfg_fg = 16'hFFFF;
  logic [15:0] cfg_bg = 16'h0000;
  logic [9:0]  clip_w = 10'd0;
  logic [9:0]  clip_h = 10'd0;
  logic [9:0]  rows_done = 10'd0;
  logic [6:0]  byte_pos = 7'd0;
  logic        blit_on = 1'b0;

  in_word_t  in_words[$];
  out_word_t out_expect[$];
  in_word_t  next_in;

  int tx_idle = 32;
  int rx_idle = 71;
  logic hold_arm = 1'b0;
  logic hold_done = 1'b0;
  int hold_left = 0;
  int stall_cycles = 0;
  int n_in = 0;
  int n_out = 0;
  int n_starts = 0;
  int n_err = 0;

  mono_bitmap_blit_stream u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_operation    (in_operation),
    .in_bitmap_byte  (in_bitmap_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_is_data     (out_is_data),
    .out_bus_word    (out_bus_word),
    .out_last_of_run (out_last_of_run),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always #6 clk = ~clk;

  function automatic void push_word(input logic is_data, input int value);
    out_word_t w;
    w.is_data   = is_data;
    w.value     = value[15:0];
    w.last_flag = 1'b0;
    out_expect.push_back(w);
  endfunction

  function automatic void push_range(input logic [7:0] cmd, input int lo, input int hi);
    push_word(1'b0, cmd);
    push_word(1'b1, (lo >> 8) & 'hFF);
    push_word(1'b1, lo & 'hFF);
    push_word(1'b1, (hi >> 8) & 'hFF);
    push_word(1'b1, hi & 'hFF);
  endfunction

  task automatic predict_blit(input logic op, input logic [7:0] pixels);
    int n_before, stride, col, left_i, top_i;
    out_word_t tail;
    n_before = out_expect.size();
    left_i = cfg_left;
    top_i = cfg_top;
    if (op == OP_START) begin
      n_starts++;
      rows_done = '0;
      byte_pos = '0;
      blit_on = 1'b0;
      clip_w = '0;
      clip_h = '0;
      if (left_i < SCREEN_W && top_i < SCREEN_H && cfg_width != 0 && cfg_height != 0) begin
        clip_w = 10'((left_i + cfg_width > SCREEN_W) ? SCREEN_W - left_i : cfg_width);
        clip_h = 10'((top_i + cfg_height > SCREEN_H) ? SCREEN_H - top_i : cfg_height);
        blit_on = 1'b1;
        push_range(CMD_COLUMN_SET, left_i, left_i + clip_w - 1);
        push_range(CMD_ROW_SET, top_i, top_i + clip_h - 1);
        push_word(1'b0, CMD_MEMORY_WRITE);
      end
    end else if (blit_on) begin
      if (rows_done < clip_h) begin
        for (int i = 0; i < 8; i++) begin
          col = byte_pos * 8 + i;
          if (col >= clip_w) break;
          push_word(1'b1, pixels[i] ? cfg_fg : cfg_bg);
        end
      end
      // stride follows the live width register
      stride = (cfg_width + 7) >> 3;
      if (byte_pos + 1 >= stride) begin
        byte_pos = '0;
        if (rows_done < ROW_MAX) rows_done = rows_done + 1'b1;
      end else begin
        byte_pos = byte_pos + 1'b1;
      end
    end
    if (out_expect.size() > n_before) begin
      tail = out_expect.pop_back();
      tail.last_flag = 1'b1;
      out_expect.push_back(tail);
    end
  endtask

  task automatic check_word();
    out_word_t want;
    n_out++;
    if (out_expect.size() == 0) begin
      n_err++;
      $display("%0t: unexpected word: expected none, actual is_data=%0b bus_word=%h last=%0b",
               $time, out_is_data, out_bus_word, out_last_of_run);
    end else begin
      want = out_expect.pop_front();
      if ({out_is_data, out_bus_word, out_last_of_run} !== want) begin
        n_err++;
        $display("%0t: mismatch: expected is_data=%0b bus_word=%h last=%0b", $time,
                 want.is_data, want.value, want.last_flag);
        $display("%0t:           actual is_data=%0b bus_word=%h last=%0b", $time,
                 out_is_data, out_bus_word, out_last_of_run);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_words.size() != 0 && $urandom_range(99) >= tx_idle) begin
        next_in = in_words.pop_front();
        in_valid <= 1'b1;
        in_operation <= next_in.op;
        in_bitmap_byte <= next_in.pixels;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_arm && !hold_done && in_valid && in_ready) begin
      out_ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      out_ready <= $urandom_range(99) >= rx_idle;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        n_in++;
        predict_blit(in_operation, in_bitmap_byte);
      end
      if (out_valid && out_ready) check_word();
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no handshake for %0d cycles, %0d words still expected", $time,
                 STALL_LIMIT, out_expect.size());
        $display("mono_bitmap_blit_stream test failed");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  function automatic void queue_word(input logic op, input logic [7:0] pixels);
    in_word_t w;
    w.op = op;
    w.pixels = pixels;
    in_words.push_back(w);
  endfunction

  task automatic settle();
    while (in_words.size() != 0 || in_valid || out_expect.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic reg_write(input logic [2:0] idx, input int val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_WIN_LEFT:   cfg_left = val[15:0];
      REG_WIN_TOP:    cfg_top = val[15:0];
      REG_BMP_WIDTH:  cfg_width = val[9:0];
      REG_BMP_HEIGHT: cfg_height = val[9:0];
      REG_FG_COLOR:   cfg_fg = val[15:0];
      REG_BG_COLOR:   cfg_bg = val[15:0];
      default: ;
    endcase
  endtask

  function automatic int pick_color();
    int r;
    r = $urandom_range(99);
    if (r < 10) return 0;
    if (r < 20) return 'hFFFF;
    return $urandom_range('hFFFF);
  endfunction

  // returns the number of input words queued
  task automatic random_blit(output int n_sent);
    int r, left_i, top_i, w_i, h_i, stride, n_full, n_bytes, n_stray;
    n_sent = 0;
    n_stray = 0;
    r = $urandom_range(99);
    if (r < 85) begin
      settle();
      r = $urandom_range(99);
      left_i = (r < 6) ? $urandom_range(65535, 240) :
               (r < 20) ? $urandom_range(239, 200) : $urandom_range(239);
      r = $urandom_range(99);
      top_i = (r < 6) ? $urandom_range(65535, 320) :
              (r < 20) ? $urandom_range(319, 290) : $urandom_range(319);
      r = $urandom_range(99);
      w_i = (r < 4) ? 0 : (r < 10) ? $urandom_range(1023, 200) : $urandom_range(24, 1);
      r = $urandom_range(99);
      h_i = (r < 4) ? 0 : (r < 10) ? $urandom_range(1023, 300) : $urandom_range(4, 1);
      reg_write(REG_WIN_LEFT, left_i);
      reg_write(REG_WIN_TOP, top_i);
      reg_write(REG_BMP_WIDTH, w_i);
      reg_write(REG_BMP_HEIGHT, h_i);
      reg_write(REG_FG_COLOR, pick_color());
      reg_write(REG_BG_COLOR, pick_color());
    end
    // stray bytes ahead of the start
    if ($urandom_range(9) == 0) begin
      n_stray = $urandom_range(3, 1);
      repeat (n_stray) queue_word(OP_BYTE, $urandom_range(255));
    end
    stride = (cfg_width + 7) >> 3;
    n_full = stride * cfg_height;
    if (n_full > 24) n_full = 24;
    n_bytes = ($urandom_range(4) == 0) ? $urandom_range(n_full) : n_full + $urandom_range(2);
    queue_word(OP_START, $urandom_range(255));
    repeat (n_bytes) queue_word(OP_BYTE, $urandom_range(255));
    n_sent = n_stray + 1 + n_bytes;
  endtask

  initial begin
    int n_rand, n_blit;
    bit pressed;
    n_rand = 0;
    pressed = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // no blit active, then an empty bitmap
    queue_word(OP_BYTE, 8'h5A);
    queue_word(OP_START, 8'h00);
    queue_word(OP_BYTE, 8'hFF);
    settle();

    // bottom right corner: clipped columns and rows, bytes past the visible rows
    reg_write(REG_WIN_LEFT, 236);
    reg_write(REG_WIN_TOP, 318);
    reg_write(REG_BMP_WIDTH, 9);
    reg_write(REG_BMP_HEIGHT, 3);
    reg_write(REG_FG_COLOR, 'h0000);
    reg_write(REG_BG_COLOR, 'hFFFF);
    queue_word(OP_START, 8'h00);
    queue_word(OP_BYTE, 8'h01);
    queue_word(OP_BYTE, 8'hFE);
    queue_word(OP_BYTE, 8'h80);
    queue_word(OP_BYTE, 8'h7F);
    queue_word(OP_BYTE, 8'hFF);
    queue_word(OP_BYTE, 8'h00);
    settle();

    // full screen with the widest bitmap
    reg_write(REG_WIN_LEFT, 0);
    reg_write(REG_WIN_TOP, 0);
    reg_write(REG_BMP_WIDTH, 1023);
    reg_write(REG_BMP_HEIGHT, 1023);
    reg_write(REG_FG_COLOR, 'hFFFF);
    reg_write(REG_BG_COLOR, 'h0000);
    queue_word(OP_START, 8'h00);
    queue_word(OP_BYTE, 8'hA5);
    queue_word(OP_BYTE, 8'h00);
    queue_word(OP_BYTE, 8'hFF);
    settle();

    // stride and colors change under a running blit
    reg_write(REG_BMP_WIDTH, 3);
    reg_write(REG_FG_COLOR, 'h1234);
    reg_write(REG_BG_COLOR, 'hFEDC);
    queue_word(OP_BYTE, 8'h55);
    queue_word(OP_BYTE, 8'hAA);
    settle();

    // off screen to the right, then below
    reg_write(REG_WIN_LEFT, 'hFFFF);
    reg_write(REG_BMP_WIDTH, 8);
    queue_word(OP_START, 8'h00);
    queue_word(OP_BYTE, 8'hC3);
    settle();
    reg_write(REG_WIN_LEFT, 239);
    reg_write(REG_WIN_TOP, 'hFFFF);
    queue_word(OP_START, 8'h00);
    queue_word(OP_BYTE, 8'h3C);
    settle();

    // single pixel in the last corner
    reg_write(REG_WIN_TOP, 319);
    reg_write(REG_BMP_WIDTH, 1);
    reg_write(REG_BMP_HEIGHT, 1);
    queue_word(OP_START, 8'h00);
    queue_word(OP_BYTE, 8'h01);
    queue_word(OP_BYTE, 8'h00);
    settle();
    reg_write(REG_BMP_HEIGHT, 0);
    queue_word(OP_START, 8'h00);

    while (n_rand < RANDOM_WORDS) begin
      if (n_rand >= 2 * RANDOM_WORDS / 3) begin
        tx_idle <= 0;
        rx_idle <= 0;
      end else if (n_rand >= RANDOM_WORDS / 3) begin
        tx_idle <= 71;
        rx_idle <= 32;
      end
      if (!pressed && n_rand >= 2 * RANDOM_WORDS / 3) begin
        // long output stall while a dense blit keeps coming
        pressed = 1;
        settle();
        reg_write(REG_WIN_LEFT, 0);
        reg_write(REG_WIN_TOP, 0);
        reg_write(REG_BMP_WIDTH, 64);
        reg_write(REG_BMP_HEIGHT, 4);
        hold_arm <= 1'b1;
        queue_word(OP_START, 8'h00);
        repeat (32) queue_word(OP_BYTE, $urandom_range(255));
        n_rand += 33;
      end else begin
        random_blit(n_blit);
        n_rand += n_blit;
      end
    end

    settle();
    $display("Sent %0d input words (%0d blit starts), checked %0d output words;", n_in,
             n_starts, n_out);
    $display("clipping, off-screen, empty and live-register cases, three idle mixes, %0d errors.",
             n_err);
    if (n_err == 0) begin
      $display("mono_bitmap_blit_stream test passed");
    end else begin
      $display("mono_bitmap_blit_stream test failed");
    end
    $finish;
  end

endmodule
